>>> rtl/core/wmsr_pkg.sv
// Shared types, constants and lookup functions of the wheel mark speed regulator.
package wmsr_pkg;

	// Default widths of the sensor reading and of the mark and tick counters
	localparam int unsigned SENSOR_BITS_DEF = 12;
	localparam int unsigned COUNT_BITS_DEF  = 16;

	// Fixed field widths
	localparam int unsigned DUTY_W      = 15;
	localparam int unsigned SERVO_W     = 14;
	localparam int unsigned SEEN_W      = 16;
	localparam int unsigned STEP_W      = 16;
	localparam int unsigned DEAD_W      = 4;
	localparam int unsigned TURN_W      = 3;
	localparam int unsigned SPEED_W     = 2;
	localparam int unsigned TARGET_W    = 8;
	localparam int unsigned THRESH_W    = 12;
	localparam int unsigned PERIOD_W    = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 48;

	// Duties in 0.001 % units
	localparam logic [DUTY_W-1:0] DUTY_STOP  = 15'd7000;
	localparam logic [DUTY_W-1:0] DUTY_MAX   = 15'd20000;
	localparam logic [DUTY_W-1:0] BASE_RST_SLOW   = 15'd6350;
	localparam logic [DUTY_W-1:0] BASE_RST_NORMAL = 15'd6280;
	localparam logic [DUTY_W-1:0] BASE_RST_TURBO  = 15'd6200;
	localparam logic [DUTY_W-1:0] FLOOR_SLOW   = 15'd6100;
	localparam logic [DUTY_W-1:0] FLOOR_NORMAL = 15'd6000;
	localparam logic [DUTY_W-1:0] FLOOR_TURBO  = 15'd5900;

	// Graded correction steps
	localparam logic [STEP_W-1:0] STEP_FINE   = 16'd50;
	localparam logic [STEP_W-1:0] STEP_MID    = 16'd150;
	localparam logic [STEP_W-1:0] STEP_COARSE = 16'd200;

	localparam logic [DEAD_W-1:0] DEAD_MAX = 4'd15;

	// Register reset values
	localparam logic [THRESH_W-1:0] THRESH_RST   = 12'd1900;
	localparam logic [TARGET_W-1:0] SLOW_TGT_RST = 8'd2;
	localparam logic [TARGET_W-1:0] NORM_TGT_RST = 8'd3;
	localparam logic [TARGET_W-1:0] TURB_TGT_RST = 8'd4;
	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd1000;
	localparam logic [DEAD_W-1:0]   DEAD_LIM_RST = 4'd4;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_DRIVE  = 1'b1
	} op_t;

	typedef enum logic [SPEED_W-1:0] {
		SPEED_STOP   = 2'd0,
		SPEED_SLOW   = 2'd1,
		SPEED_NORMAL = 2'd2,
		SPEED_TURBO  = 2'd3
	} speed_t;

	typedef enum logic [TURN_W-1:0] {
		TURN_HARD_LEFT    = 3'd0,
		TURN_SLIGHT_LEFT  = 3'd1,
		TURN_STRAIGHT     = 3'd2,
		TURN_SLIGHT_RIGHT = 3'd3,
		TURN_HARD_RIGHT   = 3'd4
	} turn_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD     = 3'd0,
		REG_SLOW_TARGET   = 3'd1,
		REG_NORMAL_TARGET = 3'd2,
		REG_TURBO_TARGET  = 3'd3,
		REG_CHECK_PERIOD  = 3'd4,
		REG_DEAD_LIMIT    = 3'd5
	} reg_idx_t;

	// Configuration register file contents
	typedef struct packed {
		logic [THRESH_W-1:0] mark_level;
		logic [TARGET_W-1:0] slow_target;
		logic [TARGET_W-1:0] normal_target;
		logic [TARGET_W-1:0] turbo_target;
		logic [PERIOD_W-1:0] check_period;
		logic [DEAD_W-1:0]   dead_limit;
	} cfg_t;

	// Correction step: direction, amount, and a flag for a step past full scale
	typedef struct packed {
		logic              dec;
		logic              inc;
		logic              big;
		logic [STEP_W-1:0] amt;
	} step_t;

	// Result item; last member sits in the lowest bits
	typedef struct packed {
		logic               feedback_on;
		logic [SEEN_W-1:0]  marks_seen;
		logic               speed_fault;
		logic [DUTY_W-1:0]  motor_duty;
		logic [SERVO_W-1:0] servo_duty;
	} res_t;

	// Steering duty per turn code; unused codes steer straight
	function automatic logic [SERVO_W-1:0] servo_of(input logic [TURN_W-1:0] turn);
		logic [SERVO_W-1:0] d;
		case (turn)
			TURN_HARD_LEFT:    d = 14'd9000;
			TURN_SLIGHT_LEFT:  d = 14'd8000;
			TURN_STRAIGHT:     d = 14'd7500;
			TURN_SLIGHT_RIGHT: d = 14'd6500;
			TURN_HARD_RIGHT:   d = 14'd5700;
			default:           d = 14'd7500;
		endcase
		return d;
	endfunction

	// Lowest usable duty per speed; stop has none
	function automatic logic [DUTY_W-1:0] floor_of(input logic [SPEED_W-1:0] speed);
		logic [DUTY_W-1:0] f;
		case (speed)
			SPEED_SLOW:   f = FLOOR_SLOW;
			SPEED_NORMAL: f = FLOOR_NORMAL;
			SPEED_TURBO:  f = FLOOR_TURBO;
			default:      f = '0;
		endcase
		return f;
	endfunction

endpackage

>>> rtl/core/wmsr_cfg_regs.sv
// Configuration register file written through the cfg transfer channel.
module wmsr_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wmsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wmsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output wmsr_pkg::cfg_t                      cfg
);
	import wmsr_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark_level      <= THRESH_RST;
			cfg_q.slow_target     <= SLOW_TGT_RST;
			cfg_q.normal_target   <= NORM_TGT_RST;
			cfg_q.turbo_target    <= TURB_TGT_RST;
			cfg_q.check_period    <= PERIOD_RST;
			cfg_q.dead_limit      <= DEAD_LIM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD:     cfg_q.mark_level      <= cfg_data[THRESH_W-1:0];
				REG_SLOW_TARGET:   cfg_q.slow_target     <= cfg_data[TARGET_W-1:0];
				REG_NORMAL_TARGET: cfg_q.normal_target   <= cfg_data[TARGET_W-1:0];
				REG_TURBO_TARGET:  cfg_q.turbo_target    <= cfg_data[TARGET_W-1:0];
				REG_CHECK_PERIOD:  cfg_q.check_period    <= cfg_data[PERIOD_W-1:0];
				REG_DEAD_LIMIT:    cfg_q.dead_limit      <= cfg_data[DEAD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/wmsr_step.sv
// Graded correction step from the gap between target and counted marks.
module wmsr_step #(
	parameter int unsigned COUNT_BITS = wmsr_pkg::COUNT_BITS_DEF
) (
	input  logic [wmsr_pkg::TARGET_W-1:0] target,
	input  logic [COUNT_BITS-1:0]         marks,
	output wmsr_pkg::step_t               step
);
	import wmsr_pkg::*;

	// Gaps of 2048 and up push any duty past full scale, so 11 bits suffice
	localparam int unsigned DW      = (COUNT_BITS > 11) ? COUNT_BITS : 12;
	localparam int unsigned X_W     = 18;
	localparam int unsigned R_W     = 19;
	localparam int unsigned P_W     = X_W + R_W;
	localparam int unsigned R_SHIFT = 21;
	// ceil(2^21 / 6): exact floor(x / 6) for x below 2^18
	localparam logic [R_W-1:0] RECIP6 = 19'd349526;

	logic [DW-1:0]       marks_w;
	logic [DW-1:0]       target_w;
	logic [DW-1:0]       d_ex;
	logic [TARGET_W-1:0] d_sh;
	logic [X_W-1:0]      x;
	logic [P_W-1:0]      prod;
	logic [STEP_W-1:0]   q;

	assign marks_w  = DW'(marks);
	assign target_w = DW'(target);
	assign d_ex     = marks_w - target_w;
	// Only used when marks is below target, so marks fits in the target width
	assign d_sh     = target - marks[TARGET_W-1:0];

	// Excess step: 50 + (1000*d + 30) / 60 = 50 + (100*d + 3) / 6
	assign x    = X_W'(d_ex[10:0]) * X_W'(100) + X_W'(3);
	assign prod = P_W'(x) * P_W'(RECIP6);
	assign q    = prod[R_SHIFT +: STEP_W];

	always_comb begin
		step.dec = target_w > marks_w;
		step.inc = marks_w > target_w;
		step.big = step.inc && (|d_ex[DW-1:11]);
		if (step.dec) begin
			if (d_sh < TARGET_W'(3))      step.amt = STEP_FINE;
			else if (d_sh < TARGET_W'(5)) step.amt = STEP_MID;
			else                          step.amt = STEP_COARSE;
		end else if (step.inc) begin
			if (d_ex < DW'(3))            step.amt = STEP_FINE;
			else if (d_ex < DW'(5))       step.amt = STEP_MID;
			else                          step.amt = STEP_FINE + q;
		end else begin
			step.amt = '0;
		end
	end

endmodule

>>> rtl/core/wmsr_loop.sv
// Regulator state and the single pass that handles one sample or drive command.
module wmsr_loop #(
	parameter int unsigned SENSOR_BITS = wmsr_pkg::SENSOR_BITS_DEF,
	parameter int unsigned COUNT_BITS  = wmsr_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  wmsr_pkg::op_t                 op,
	input  logic [SENSOR_BITS-1:0]        light_sample,
	input  logic                          button_down,
	input  logic [wmsr_pkg::TURN_W-1:0]   turn_code,
	input  logic [wmsr_pkg::SPEED_W-1:0]  speed_code,
	input  wmsr_pkg::cfg_t                cfg,
	output wmsr_pkg::res_t                res
);
	import wmsr_pkg::*;

	localparam int unsigned TW = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                   mark_flag_q;
	logic [COUNT_BITS-1:0]  mark_cnt_q;
	logic [COUNT_BITS-1:0]  tick_cnt_q;
	logic [DEAD_W-1:0]      dead_q;
	logic                   latch_q;
	logic                   fb_q;
	logic [DUTY_W-1:0]      base_q [3];

	logic [SENSOR_BITS-1:0] thr;
	logic                   above;
	logic                   below;
	logic                   fb_next;
	logic                   is_run;
	logic [DUTY_W-1:0]      base_sel;
	logic [TARGET_W-1:0]    target;
	logic                   check;
	logic [DEAD_W-1:0]      dead_next;
	logic                   adjust;
	step_t                  step;
	logic [STEP_W:0]        sum;
	logic [STEP_W-1:0]      base_ext;
	logic [DUTY_W-1:0]      adj_duty;
	logic [DUTY_W-1:0]      work;
	logic                   ok;

	// Sample side: threshold compare, equal level holds the flag
	assign thr   = SENSOR_BITS'(cfg.mark_level);
	assign above = light_sample > thr;
	assign below = light_sample < thr;

	// Switch edge toggles feedback
	assign fb_next = (button_down && !latch_q) ? !fb_q : fb_q;
	assign is_run  = speed_code != SPEED_STOP;

	// Stored base duty and target for the commanded speed
	always_comb begin
		case (speed_code)
			SPEED_SLOW:   begin base_sel = base_q[0]; target = cfg.slow_target;   end
			SPEED_NORMAL: begin base_sel = base_q[1]; target = cfg.normal_target; end
			SPEED_TURBO:  begin base_sel = base_q[2]; target = cfg.turbo_target;  end
			default:      begin base_sel = DUTY_STOP; target = '0;                end
		endcase
	end

	// Period check and markless-period count
	assign check = (TW'(tick_cnt_q) > TW'(cfg.check_period)) && fb_next;

	always_comb begin
		if (!check) begin
			dead_next = dead_q;
		end else if (mark_cnt_q == '0 && is_run) begin
			dead_next = (dead_q == DEAD_MAX) ? dead_q : dead_q + DEAD_W'(1);
		end else begin
			dead_next = '0;
		end
	end

	assign adjust = check && (dead_next < cfg.dead_limit) && is_run;

	wmsr_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.target (target),
		.marks  (mark_cnt_q),
		.step   (step)
	);

	// Saturating move of the duty by the step
	assign base_ext = STEP_W'(base_sel);
	assign sum      = (STEP_W+1)'(base_ext) + (STEP_W+1)'(step.amt);

	always_comb begin
		if (step.dec) begin
			adj_duty = (base_ext > step.amt) ? DUTY_W'(base_ext - step.amt) : '0;
		end else if (step.inc) begin
			adj_duty = (step.big || sum > (STEP_W+1)'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(sum);
		end else begin
			adj_duty = base_sel;
		end
	end

	assign work = !is_run ? DUTY_STOP : (adjust ? adj_duty : base_sel);
	assign ok   = (!is_run || work >= floor_of(speed_code)) && (dead_next < cfg.dead_limit);

	// Result of a drive command
	assign res.servo_duty  = servo_of(turn_code);
	assign res.motor_duty  = ok ? work : DUTY_STOP;
	assign res.speed_fault = !ok;
	assign res.marks_seen  = SEEN_W'(mark_cnt_q);
	assign res.feedback_on = fb_next;

	// State update on each handled item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_flag_q <= 1'b0;
			mark_cnt_q  <= '0;
			tick_cnt_q  <= '0;
			dead_q      <= '0;
			latch_q     <= 1'b0;
			fb_q        <= 1'b1;
			base_q[0]   <= BASE_RST_SLOW;
			base_q[1]   <= BASE_RST_NORMAL;
			base_q[2]   <= BASE_RST_TURBO;
		end else if (fire) begin
			if (op == OP_SAMPLE) begin
				if (above && !mark_flag_q) begin
					mark_flag_q <= 1'b1;
					if (mark_cnt_q != CNT_MAX) mark_cnt_q <= mark_cnt_q + COUNT_BITS'(1);
				end else if (below && mark_flag_q) begin
					mark_flag_q <= 1'b0;
				end
				if (tick_cnt_q != CNT_MAX) tick_cnt_q <= tick_cnt_q + COUNT_BITS'(1);
			end else begin
				latch_q <= button_down;
				fb_q    <= fb_next;
				dead_q  <= dead_next;
				if (check) begin
					tick_cnt_q <= '0;
					mark_cnt_q <= '0;
				end
				if (adjust && speed_code == SPEED_SLOW)   base_q[0] <= adj_duty;
				if (adjust && speed_code == SPEED_NORMAL) base_q[1] <= adj_duty;
				if (adjust && speed_code == SPEED_TURBO)  base_q[2] <= adj_duty;
			end
		end
	end

endmodule

>>> rtl/core/wheel_mark_speed_regulator.sv
// Wheel mark speed regulator: input register, regulator pass and result register.
// The block takes one item per clock unless a held drive command stalls it.
// An accepted item sits in the input register while the regulator pass reads
// it with the current state; at the edge on which it leaves, the state is
// updated and, for a drive command, the result is loaded into the output
// register, which offers it on the master side. Light sensor samples produce
// no result. The only thing that slows intake is a drive command meeting a
// full output register that the sink does not drain; a sample in the input
// register leaves even then, but items behind a held command wait.
// Configuration writes are taken in any cycle and should be made while no
// item is in flight.
module wheel_mark_speed_regulator #(
	parameter int unsigned SENSOR_BITS = wmsr_pkg::SENSOR_BITS_DEF,
	parameter int unsigned COUNT_BITS  = wmsr_pkg::COUNT_BITS_DEF,
	localparam int unsigned IN_TDATA_W = ((SENSOR_BITS + 6 + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Sensor samples and drive commands
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// light_sample, button_down, turn_code, speed_code, zero fill
	input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
	// op
	input  logic                                s_axis_tuser,
	// Results
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// servo_duty, motor_duty, speed_fault, marks_seen, feedback_on, zero fill
	output logic [wmsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// Register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wmsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wmsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wmsr_pkg::*;

	localparam int unsigned SB = SENSOR_BITS;

	cfg_t                 cfg;
	res_t                 res;
	res_t                 out_q;
	logic                 out_vld_q;

	logic                 vld_s1;
	op_t                  op_s1;
	logic [SB-1:0]        sample_s1;
	logic                 btn_s1;
	logic [TURN_W-1:0]    turn_s1;
	logic [SPEED_W-1:0]   speed_s1;

	logic                 fire;
	logic                 in_xfer;

	// Item leaves the input register unless a result has nowhere to go
	assign fire          = vld_s1 && (op_s1 == OP_SAMPLE || !out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || fire;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_xfer) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1     <= op_t'(s_axis_tuser);
			sample_s1 <= s_axis_tdata[SB-1:0];
			btn_s1    <= s_axis_tdata[SB];
			turn_s1   <= s_axis_tdata[SB+1 +: TURN_W];
			speed_s1  <= s_axis_tdata[SB+1+TURN_W +: SPEED_W];
		end
	end

	wmsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wmsr_loop #(
		.SENSOR_BITS (SENSOR_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_loop (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.op           (op_s1),
		.light_sample (sample_s1),
		.button_down  (btn_s1),
		.turn_code    (turn_s1),
		.speed_code   (speed_s1),
		.cfg          (cfg),
		.res          (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire && op_s1 == OP_DRIVE) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && op_s1 == OP_DRIVE) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);

endmodule

>>> sim/wheel_mark_speed_regulator_tb.sv
// Testbench for the wheel mark speed regulator: stream driver, result checker and predictor.
`timescale 1ns / 100ps

module wheel_mark_speed_regulator_tb;
	import wmsr_pkg::*;

	localparam int unsigned IN_W      = ((SENSOR_BITS_DEF + 6 + 7) / 8) * 8;
	localparam int unsigned RUN_LIMIT = 3_000_000;
	localparam int unsigned HOLD_LEN  = 300;
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;
	localparam logic [SERVO_W-1:0] STEER_DUTY [5] = '{14'd9000, 14'd8000, 14'd7500,
		14'd6500, 14'd5700};

	// One sensor sample or drive command
	typedef struct {
		op_t         op;
		logic [11:0] light;
		logic        button;
		logic [2:0]  turn;
		speed_t      speed;
	} wheel_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_idx_t cfg_index = REG_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	wheel_mark_speed_regulator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Stimulus and expectations
	wheel_item_t pending [$];
	res_t        results_due [$];
	wheel_item_t tx_item;
	int unsigned cycle_no = 0;
	int unsigned mismatches = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned rx_hold = 0;
	logic        hold_armed = 1'b0;
	logic        hold_done = 1'b0;
	logic        quiet = 1'b0;
	logic        press_lvl = 1'b0;

	// Shadow registers
	logic [11:0] thr_q;
	logic [7:0]  target_q [3];
	logic [15:0] period_q;
	logic [3:0]  dead_lim_q;

	// Shadow regulator state
	logic        mark_high;
	logic [15:0] mark_tally;
	logic [15:0] tick_tally;
	logic [3:0]  dead_run;
	logic        btn_held;
	logic        fb_enable;
	logic [DUTY_W-1:0] base_duty_q [3];
	logic [DUTY_W-1:0] run_duty;

	function automatic logic [DUTY_W-1:0] duty_less(logic [DUTY_W-1:0] d, int unsigned amt);
		return (d > amt) ? d - DUTY_W'(amt) : '0;
	endfunction

	function automatic logic [DUTY_W-1:0] duty_more(logic [DUTY_W-1:0] d, int unsigned amt);
		int unsigned sum;
		sum = d + amt;
		return (sum > DUTY_MAX) ? DUTY_MAX : DUTY_W'(sum);
	endfunction

	// Advance the shadow state by one accepted item; drive commands queue a result
	task automatic regulate(input wheel_item_t it);
		res_t        r;
		logic [7:0]  tgt;
		int unsigned diff;
		int unsigned step;
		int          k;
		logic        fine;
		logic        ok;
		if (it.op == OP_SAMPLE) begin
			if (it.light > thr_q && !mark_high) begin
				if (mark_tally != COUNT_TOP) mark_tally++;
				mark_high = 1'b1;
			end else if (it.light < thr_q && mark_high) begin
				mark_high = 1'b0;
			end
			if (tick_tally != COUNT_TOP) tick_tally++;
		end else begin
			// switch press toggles feedback once per press
			if (it.button && !btn_held) begin
				fb_enable = !fb_enable;
				btn_held = 1'b1;
			end else if (!it.button && btn_held) begin
				btn_held = 1'b0;
			end
			r.servo_duty = (it.turn <= TURN_HARD_RIGHT) ? STEER_DUTY[it.turn]
				: STEER_DUTY[TURN_STRAIGHT];
			r.marks_seen = mark_tally;
			tgt = '0;
			k = 0;
			if (it.speed == SPEED_STOP) begin
				run_duty = DUTY_STOP;
			end else begin
				k = int'(it.speed) - 1;
				run_duty = base_duty_q[k];
				tgt = target_q[k];
			end
			// period check and graded correction
			if (tick_tally > period_q && fb_enable) begin
				tick_tally = '0;
				if (mark_tally == 0 && it.speed != SPEED_STOP) begin
					if (dead_run != DEAD_MAX) dead_run++;
				end else begin
					dead_run = '0;
				end
				if (dead_run < dead_lim_q && it.speed != SPEED_STOP) begin
					if (tgt > mark_tally) begin
						diff = int'(tgt) - int'(mark_tally);
						step = (diff < 3) ? STEP_FINE : (diff < 5) ? STEP_MID : STEP_COARSE;
						run_duty = duty_less(run_duty, step);
						base_duty_q[k] = duty_less(base_duty_q[k], step);
					end else if (tgt < mark_tally) begin
						diff = int'(mark_tally) - int'(tgt);
						step = (diff < 3) ? STEP_FINE : (diff < 5) ? STEP_MID
							: STEP_FINE + (diff * 1000 + 30) / 60;
						run_duty = duty_more(run_duty, step);
						base_duty_q[k] = duty_more(base_duty_q[k], step);
					end
				end
				mark_tally = '0;
			end
			case (it.speed)
				SPEED_SLOW:   fine = run_duty >= FLOOR_SLOW;
				SPEED_NORMAL: fine = run_duty >= FLOOR_NORMAL;
				SPEED_TURBO:  fine = run_duty >= FLOOR_TURBO;
				default:      fine = 1'b1;
			endcase
			ok = fine && dead_run < dead_lim_q;
			r.motor_duty = ok ? run_duty : DUTY_STOP;
			r.speed_fault = !ok;
			r.feedback_on = fb_enable;
			results_due.push_back(r);
		end
	endtask

	function automatic wheel_item_t sample_item(logic [11:0] lvl);
		wheel_item_t it;
		it.op = OP_SAMPLE;
		it.light = lvl;
		it.button = 1'($urandom);
		it.turn = 3'($urandom);
		it.speed = speed_t'($urandom_range(3));
		return it;
	endfunction

	function automatic wheel_item_t drive_item(logic btn, logic [2:0] turn, speed_t spd);
		wheel_item_t it;
		it.op = OP_DRIVE;
		it.light = 12'($urandom);
		it.button = btn;
		it.turn = turn;
		it.speed = spd;
		return it;
	endfunction

	function automatic logic [11:0] lvl_above();
		return (thr_q == 12'hFFF) ? thr_q : 12'($urandom_range(4095, thr_q + 1));
	endfunction

	function automatic logic [11:0] lvl_below();
		return (thr_q == 12'h000) ? thr_q : 12'($urandom_range(thr_q - 1, 0));
	endfunction

	// One feedback period: marks with random levels, some noise, then a command
	task automatic push_round();
		int unsigned marks;
		int unsigned extra;
		wheel_item_t junk;
		marks = ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(40);
		extra = $urandom_range(2);
		repeat (marks) begin
			pending.push_back(sample_item(lvl_above()));
			pending.push_back(sample_item(($urandom_range(7) == 0) ? thr_q : lvl_below()));
		end
		repeat (extra) pending.push_back(sample_item(12'($urandom)));
		if ($urandom_range(9) == 0) begin
			junk = sample_item(12'($urandom));
			junk.op = op_t'($urandom_range(1));
			pending.push_back(junk);
		end
		if ($urandom_range(4) == 0) press_lvl = !press_lvl;
		pending.push_back(drive_item(press_lvl,
			($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(4)),
			speed_t'($urandom_range(3))));
	endtask

	// Release the switch and, if feedback is off, press once more to turn it on
	task automatic feedback_on_again(speed_t spd);
		pending.push_back(drive_item(1'b0, TURN_STRAIGHT, spd));
		if (!fb_enable) begin
			pending.push_back(drive_item(1'b1, TURN_STRAIGHT, spd));
			pending.push_back(drive_item(1'b0, TURN_STRAIGHT, spd));
		end
		press_lvl = 1'b0;
	endtask

	task automatic program_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_THRESHOLD:     thr_q = val[11:0];
			REG_SLOW_TARGET:   target_q[0] = val[7:0];
			REG_NORMAL_TARGET: target_q[1] = val[7:0];
			REG_TURBO_TARGET:  target_q[2] = val[7:0];
			REG_CHECK_PERIOD:  period_q = val;
			REG_DEAD_LIMIT:    dead_lim_q = val[3:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [11:0] thr, logic [7:0] slow_t, logic [7:0] norm_t,
		logic [7:0] turbo_t, logic [15:0] period, logic [3:0] dead_lim);
		program_reg(REG_THRESHOLD, 16'(thr));
		program_reg(REG_SLOW_TARGET, 16'(slow_t));
		program_reg(REG_NORMAL_TARGET, 16'(norm_t));
		program_reg(REG_TURBO_TARGET, 16'(turbo_t));
		program_reg(REG_CHECK_PERIOD, period);
		program_reg(REG_DEAD_LIMIT, 16'(dead_lim));
	endtask

	// Wait until every item is taken and every result is back, then let the pipe drain
	task automatic settle();
		while (pending.size() != 0 || s_axis_tvalid || results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Cycle count and run limit
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sender: feeds pending items, idles in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) regulate(tx_item);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (!quiet && cycle_no[7:6] != 2'd0 && $urandom_range(5) == 0) begin
					tx_gap = $urandom_range(14);
					s_axis_tvalid <= 1'b0;
				end else if (pending.size() != 0) begin
					tx_item = pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= IN_W'({tx_item.speed, tx_item.turn, tx_item.button,
						tx_item.light});
					s_axis_tuser <= tx_item.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random stall bursts, plus one long hold-off once armed
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_hold != 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				rx_hold = HOLD_LEN - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && cycle_no[8:7] != 2'd1 && $urandom_range(5) == 0) begin
				rx_gap = $urandom_range(14);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic note_mismatch(string what, res_t want, res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected servo %0d motor %0d fault %0b seen %0d fb %0b,",
				$realtime, what, want.servo_duty, want.motor_duty, want.speed_fault,
				want.marks_seen, want.feedback_on,
				" got servo %0d motor %0d fault %0b seen %0d fb %0b",
				got.servo_duty, got.motor_duty, got.speed_fault, got.marks_seen,
				got.feedback_on);
	endtask

	// Result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
			if (results_due.size() == 0) begin
				note_mismatch("result with nothing pending", '0, got);
			end else begin
				want = results_due.pop_front();
				if (got.servo_duty !== want.servo_duty || got.motor_duty !== want.motor_duty ||
					got.speed_fault !== want.speed_fault ||
					got.marks_seen !== want.marks_seen ||
					got.feedback_on !== want.feedback_on)
					note_mismatch("drive result mismatch", want, got);
			end
		end
	end

	initial begin
		thr_q = THRESH_RST;
		target_q = '{SLOW_TGT_RST, NORM_TGT_RST, TURB_TGT_RST};
		period_q = PERIOD_RST;
		dead_lim_q = DEAD_LIM_RST;
		mark_high = 1'b0;
		mark_tally = '0;
		tick_tally = '0;
		dead_run = '0;
		btn_held = 1'b0;
		fb_enable = 1'b1;
		base_duty_q = '{BASE_RST_SLOW, BASE_RST_NORMAL, BASE_RST_TURBO};
		run_duty = DUTY_STOP;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: level equal to threshold, crossings, all turns and speeds
		pending.push_back(sample_item(12'd1900));
		pending.push_back(sample_item(12'd1901));
		pending.push_back(sample_item(12'd4095));
		pending.push_back(sample_item(12'd1900));
		pending.push_back(sample_item(12'd0));
		pending.push_back(sample_item(12'd4095));
		for (int t = 0; t < 8; t++)
			pending.push_back(drive_item(1'b0, 3'(t), speed_t'(t % 4)));
		// switch held across two commands toggles only once
		pending.push_back(drive_item(1'b1, TURN_STRAIGHT, SPEED_SLOW));
		pending.push_back(drive_item(1'b1, TURN_STRAIGHT, SPEED_NORMAL));
		pending.push_back(drive_item(1'b0, TURN_STRAIGHT, SPEED_TURBO));
		pending.push_back(drive_item(1'b1, TURN_HARD_LEFT, SPEED_STOP));
		pending.push_back(drive_item(1'b0, TURN_HARD_RIGHT, SPEED_SLOW));
		settle();

		// Moderate settings with a long sink stall
		program_all(12'd2000, 8'd2, 8'd3, 8'd4, 16'd4, 4'd4);
		hold_armed <= 1'b1;
		repeat (7) push_round();
		settle();

		// Extremes: zero threshold and period, widest dead limit; markless periods pile up
		program_all(12'd0, 8'd0, 8'd255, 8'd128, 16'd0, 4'd15);
		feedback_on_again(SPEED_TURBO);
		repeat (18) begin
			pending.push_back(sample_item(12'd4095));
			pending.push_back(drive_item(1'b0, TURN_SLIGHT_LEFT, SPEED_TURBO));
		end
		repeat (4) push_round();
		settle();

		// Top threshold and dead limit of zero: every command reports the stop duty
		program_all(12'd4095, 8'd255, 8'd255, 8'd255, 16'd1, 4'd0);
		repeat (3) push_round();
		settle();

		// Random settings, twice; large targets drive duties to the floor
		repeat (2) begin
			program_all(12'($urandom_range(4094, 1)), 8'($urandom_range(10)),
				8'($urandom_range(10)), 8'($urandom_range(40)), 16'($urandom_range(6)),
				4'($urandom_range(15, 1)));
			repeat (5) push_round();
			settle();
		end

		// No idling from here
		quiet <= 1'b1;
		program_all(THRESH_RST, SLOW_TGT_RST, NORM_TGT_RST, TURB_TGT_RST, 16'd2, DEAD_LIM_RST);
		repeat (4) push_round();
		settle();

		if (mismatches == 0 && results_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> wheel_mark_speed_regulator.f
rtl/core/wmsr_pkg.sv
rtl/core/wmsr_cfg_regs.sv
rtl/core/wmsr_step.sv
rtl/core/wmsr_loop.sv
rtl/core/wheel_mark_speed_regulator.sv
sim/wheel_mark_speed_regulator_tb.sv
